>>> rtl/core/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg: shared types and constants for the laser point transform
// Holds the register indexes, the CORDIC arctangent table and the config struct.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int GUARD_BITS   = 8;
  localparam int OUT_W        = 17;
  localparam int OUT_MAX      = 65535;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_ROLL   = 3'd0,
    REG_SIN_ROLL   = 3'd1,
    REG_COS_PITCH  = 3'd2,
    REG_SIN_PITCH  = 3'd3,
    REG_COS_YAW    = 3'd4,
    REG_SIN_YAW    = 3'd5,
    REG_YAW_ENABLE = 3'd6,
    REG_SPARE      = 3'd7
  } cfg_idx_e;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [33:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
      3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
      9: a = 32'h00145F2F;  10: a = 32'h000A2F98; 11: a = 32'h000517CC;
      12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2FA;
      15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
      18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
      21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
      24: a = 32'h00000029; 25: a = 32'h00000014; 26: a = 32'h0000000A;
      default: a = 32'h00000005;
    endcase
    return {2'b00, a};
  endfunction

  typedef struct packed {
    logic signed [15:0] cos_roll;
    logic signed [15:0] sin_roll;
    logic signed [15:0] cos_pitch;
    logic signed [15:0] sin_pitch;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic               yaw_en;
  } lpt_cfg_t;

endpackage

>>> rtl/core/lpt_cordic.sv
// ----------------------------------------------------------------------------
// lpt_cordic: pipelined beam-angle sine/cosine
// Quadrant fold then a rotation-mode CORDIC, SPS iterations per
// register stage, with rounding and clamping at the end. Stalls with en_i.
// ----------------------------------------------------------------------------
module lpt_cordic #(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15,
  parameter int TAG_W          = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [ANGLE_BITS-1:0]            angle_i,
  input  logic [TAG_W-1:0]                 tag_i,
  output logic                             valid_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic [TAG_W-1:0]                 tag_o
);
  import lpt_pkg::*;

  localparam int SPS    = 4;
  localparam int NSTG   = CORDIC_STEPS / SPS;
  localparam int RSH    = 30 - TRIG_FRAC_BITS;
  localparam int TW     = TRIG_FRAC_BITS + 2;
  localparam int XW     = 34;

  logic                 v_q    [NSTG+1];
  logic signed [XW-1:0] x_q    [NSTG+1];
  logic signed [XW-1:0] y_q    [NSTG+1];
  logic signed [XW-1:0] z_q    [NSTG+1];
  logic                 flip_q [NSTG+1];
  logic [TAG_W-1:0]     tag_q  [NSTG+1];

  logic [31:0]          turn_s;
  logic [31:0]          fold_s;
  logic                 flip_s;

  always_comb begin
    turn_s = 32'(angle_i) << (32 - ANGLE_BITS);
    // beyond +-90 degrees: add half a turn
    flip_s = ($signed(turn_s) > $signed(32'h4000_0000)) ||
             ($signed(turn_s) < $signed(32'hC000_0000));
    fold_s = flip_s ? turn_s + 32'h8000_0000 : turn_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= XW'(652032874);
      y_q[0]    <= '0;
      z_q[0]    <= XW'($signed(fold_s));
      flip_q[0] <= flip_s;
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic signed [XW-1:0] xs, ys, zs;
    always_comb begin
      logic signed [XW-1:0] dx, dy;
      xs = x_q[g];
      ys = y_q[g];
      zs = z_q[g];
      for (int k = 0; k < SPS; k++) begin
        dx = ys >>> (g * SPS + k);
        dy = xs >>> (g * SPS + k);
        if (!zs[XW-1]) begin
          xs = xs - dx;
          ys = ys + dy;
          zs = zs - atan_turn(g * SPS + k);
        end else begin
          xs = xs + dx;
          ys = ys - dy;
          zs = zs + atan_turn(g * SPS + k);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]    <= xs;
        y_q[g+1]    <= ys;
        z_q[g+1]    <= zs;
        flip_q[g+1] <= flip_q[g];
        tag_q[g+1]  <= tag_q[g];
      end
    end
  end

  function automatic logic signed [TW-1:0] fin(input logic signed [XW-1:0] v,
                                               input logic f);
    logic signed [XW-1:0] r;
    logic signed [XW-1:0] lim;
    r   = (v + (XW'(1) <<< (RSH - 1))) >>> RSH;
    lim = XW'(1) <<< TRIG_FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    if (f) r = -r;
    return r[TW-1:0];
  endfunction

  logic                 vo_q;
  logic signed [TW-1:0] c_q, s_q;
  logic [TAG_W-1:0]     to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q  <= fin(x_q[NSTG], flip_q[NSTG]);
      s_q  <= fin(y_q[NSTG], flip_q[NSTG]);
      to_q <= tag_q[NSTG];
    end
  end

  assign valid_o = vo_q;
  assign cos_o   = c_q;
  assign sin_o   = s_q;
  assign tag_o   = to_q;

endmodule

>>> rtl/core/laser_polar_to_tilted_cartesian.sv
// ----------------------------------------------------------------------------
// laser_polar_to_tilted_cartesian: laser return to rotated 3-D point
// Polar to planar conversion, then roll, pitch and optional yaw rotation.
// ----------------------------------------------------------------------------
// One point per cycle is accepted and delivered at full throughput unless stalled.
// The pipeline is one fold stage, seven CORDIC stages of four iterations, a trig
// rounding stage, planar multiply, roll multiply/round, pitch multiply, pitch
// sum/round, yaw multiply, yaw sum/round, and output round/saturate into the
// output register. The whole pipeline advances whenever the output register is
// free or being taken, so s_axis_tready falls only while a result waits downstream.
// Configuration registers must be written only while no point is in flight.
module laser_polar_to_tilted_cartesian #(
  parameter int RANGE_BITS     = 16,
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: range [RANGE_BITS-1:0], beam_angle above it, zero padded
  input  logic [((RANGE_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: point_x [16:0], point_y [33:17], point_z [50:34], zero padded
  output logic [55:0] m_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [lpt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lpt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lpt_pkg::*;

  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int PSH = TRIG_FRAC_BITS - GUARD_BITS;
  localparam int PW  = RANGE_BITS + GUARD_BITS + 3;   // planar with guard bits
  localparam int MW  = PW + 17;                       // after Q1.15 product
  localparam int SW  = MW + 1;

  lpt_cfg_t cfg_q;
  logic     en;

  // ---------------- configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cos_roll: 16'sd32767, sin_roll: '0, cos_pitch: 16'sd32767,
                 sin_pitch: '0, cos_yaw: 16'sd32767, sin_yaw: '0, yaw_en: 1'b1};
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_COS_ROLL:   cfg_q.cos_roll  <= cfg_data_i;
        REG_SIN_ROLL:   cfg_q.sin_roll  <= cfg_data_i;
        REG_COS_PITCH:  cfg_q.cos_pitch <= cfg_data_i;
        REG_SIN_PITCH:  cfg_q.sin_pitch <= cfg_data_i;
        REG_COS_YAW:    cfg_q.cos_yaw   <= cfg_data_i;
        REG_SIN_YAW:    cfg_q.sin_yaw   <= cfg_data_i;
        REG_YAW_ENABLE: cfg_q.yaw_en    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- beam trig
  logic                 c_v;
  logic signed [TW-1:0] cb, sb;
  logic [RANGE_BITS-1:0] c_r;

  lpt_cordic #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .TAG_W         (RANGE_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .angle_i(s_axis_tdata[RANGE_BITS +: ANGLE_BITS]),
    .tag_i  (s_axis_tdata[RANGE_BITS-1:0]),
    .valid_o(c_v),
    .cos_o  (cb),
    .sin_o  (sb),
    .tag_o  (c_r)
  );

  function automatic logic signed [SW-1:0] rnd15(input logic signed [SW-1:0] v);
    return (v + SW'(16384)) >>> 15;
  endfunction

  // stage A: planar multiply and round
  logic signed [PW-1:0] ax_q, ay_q;
  logic                 av_q;
  logic signed [RANGE_BITS+TW:0] mx, my;
  always_comb begin
    mx = $signed({1'b0, c_r}) * cb;
    my = $signed({1'b0, c_r}) * sb;
    if (PSH > 0) begin
      mx = (mx + ((RANGE_BITS+TW+1)'(1) <<< (PSH > 0 ? PSH - 1 : 0))) >>> PSH;
      my = (my + ((RANGE_BITS+TW+1)'(1) <<< (PSH > 0 ? PSH - 1 : 0))) >>> PSH;
    end
  end

  // stage B: roll; C: pitch products; D: pitch sums; E: yaw products; F: yaw sums
  logic signed [PW-1:0] bx_q, by_q, bz_q;
  logic signed [MW-1:0] c1_q, c2_q, c3_q, c4_q;
  logic signed [PW-1:0] cy_q;
  logic signed [PW-1:0] dx_q, dy_q, dz_q;
  logic signed [MW-1:0] e1_q, e2_q, e3_q, e4_q;
  logic signed [PW-1:0] ex_q, ey_q, ez_q;
  logic                 ee_q;
  logic signed [PW-1:0] fx_q, fy_q, fz_q;
  logic                 bv_q, cv_q, dv_q, ev_q, fv_q;
  logic signed [SW-1:0] ry, rz, s1, s2, s3, s4;
  logic signed [55:0]   out_q;

  always_comb begin
    rz = rnd15(SW'(cfg_q.sin_roll * ay_q));
    ry = rnd15(SW'(cfg_q.cos_roll * ay_q));
    s1 = rnd15(SW'(c1_q) + SW'(c2_q));
    s2 = rnd15(SW'(c3_q) - SW'(c4_q));
    s3 = rnd15(SW'(e1_q) - SW'(e2_q));
    s4 = rnd15(SW'(e3_q) + SW'(e4_q));
  end

  function automatic logic [OUT_W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + PW'(128)) >>> GUARD_BITS;
    if (r > PW'(OUT_MAX)) r = PW'(OUT_MAX);
    if (r < -PW'(OUT_MAX)) r = -PW'(OUT_MAX);
    return r[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {av_q, bv_q, cv_q, dv_q, ev_q, fv_q, out_v_q} <= '0;
    end else if (en) begin
      {av_q, bv_q, cv_q, dv_q, ev_q, fv_q, out_v_q} <=
        {c_v, av_q, bv_q, cv_q, dv_q, ev_q, fv_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= PW'(mx);
      ay_q <= PW'(my);
      bx_q <= ax_q;
      by_q <= PW'(ry);
      bz_q <= PW'(rz);
      c1_q <= MW'(cfg_q.cos_pitch * bx_q);
      c2_q <= MW'(cfg_q.sin_pitch * bz_q);
      c3_q <= MW'(cfg_q.cos_pitch * bz_q);
      c4_q <= MW'(cfg_q.sin_pitch * bx_q);
      cy_q <= by_q;
      dx_q <= PW'(s1);
      dz_q <= PW'(s2);
      dy_q <= cy_q;
      e1_q <= MW'(cfg_q.cos_yaw * dx_q);
      e2_q <= MW'(cfg_q.sin_yaw * dy_q);
      e3_q <= MW'(cfg_q.sin_yaw * dx_q);
      e4_q <= MW'(cfg_q.cos_yaw * dy_q);
      ex_q <= dx_q;
      ey_q <= dy_q;
      ez_q <= dz_q;
      ee_q <= cfg_q.yaw_en;
      fx_q <= ee_q ? PW'(s3) : ex_q;
      fy_q <= ee_q ? PW'(s4) : ey_q;
      fz_q <= ez_q;
      out_q <= {5'd0, sat(fz_q), sat(fy_q), sat(fx_q)};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i) begin
    if (rst_ni && out_v_q && !m_axis_tready) begin
      assert (!s_axis_tready) else $error("pipeline advanced under stall");
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost under stall");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:51] == 5'd0)
    else $error("padding not zero");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fv_q && s_axis_tready |=> m_axis_tvalid)
    else $error("result dropped at output");

endmodule
